[rtl/ramn_pkg.sv]
// Shared types, codes and control store for the Ricart-Agrawala mutex node.
`default_nettype none
package ramn_pkg;

    localparam int STEP_W = 5;
    localparam logic [14:0] CLK_MAX = 15'h7FFF;

    // Input kinds and result actions
    localparam logic [1:0] OPC_REQ   = 2'd0;
    localparam logic [1:0] OPC_MSG   = 2'd1;
    localparam logic [1:0] OPC_REL   = 2'd2;
    localparam logic [1:0] MT_DONE   = 2'd0;
    localparam logic [1:0] MT_REQ    = 2'd1;
    localparam logic [1:0] MT_REP    = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_MCAST = 2'd1;
    localparam logic [1:0] ACT_REPLY = 2'd2;

    // Program addresses
    localparam logic [STEP_W-1:0] S_FETCH  = 5'd0;
    localparam logic [STEP_W-1:0] S_EMPTY  = 5'd4;
    localparam logic [STEP_W-1:0] S_REQ    = 5'd5;
    localparam logic [STEP_W-1:0] S_MSG    = 5'd7;
    localparam logic [STEP_W-1:0] S_DONE   = 5'd12;
    localparam logic [STEP_W-1:0] S_PREQ   = 5'd13;
    localparam logic [STEP_W-1:0] S_DEFER  = 5'd16;
    localparam logic [STEP_W-1:0] S_PREP   = 5'd17;
    localparam logic [STEP_W-1:0] S_REL    = 5'd19;
    localparam logic [STEP_W-1:0] S_LOOP   = 5'd20;
    localparam logic [STEP_W-1:0] S_NEXT   = 5'd24;
    localparam logic [STEP_W-1:0] S_FIN    = 5'd25;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_REQ, OP_MAXTICK, OP_DONE_INC, OP_TICK, OP_DEFER,
        OP_RPL_DEC, OP_REL_START, OP_IDX_INC, OP_REL_END
    } t_op;

    typedef enum logic [2:0] {
        E_NONE, E_EMPTY, E_MCAST, E_RPL_SND, E_RPL_PEER, E_GRANT
    } t_emit;

    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_NO_ITEM, C_OP_REQ, C_OP_MSG, C_OP_REL, C_MT_DONE,
        C_MT_REQ, C_MT_REP, C_DEFER, C_PEER_END, C_NOT_DEF, C_SENT
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_emit             emit;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic item_valid;
        logic out_busy;
        logic op_req;
        logic op_msg;
        logic op_rel;
        logic mt_done;
        logic mt_req;
        logic mt_rep;
        logic defer;
        logic peer_end;
        logic not_def;
        logic sent;
    } t_status;

    function automatic t_ctrl rom_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        unique case (step)
            5'd0:  w = '{OP_LOAD,      E_NONE,     C_NO_ITEM,  S_FETCH};
            5'd1:  w = '{OP_NONE,      E_NONE,     C_OP_REQ,   S_REQ};
            5'd2:  w = '{OP_NONE,      E_NONE,     C_OP_MSG,   S_MSG};
            5'd3:  w = '{OP_NONE,      E_NONE,     C_OP_REL,   S_REL};
            5'd4:  w = '{OP_NONE,      E_EMPTY,    C_ALWAYS,   S_FETCH};
            5'd5:  w = '{OP_REQ,       E_NONE,     C_NEVER,    S_FETCH};
            5'd6:  w = '{OP_NONE,      E_MCAST,    C_ALWAYS,   S_FETCH};
            5'd7:  w = '{OP_MAXTICK,   E_NONE,     C_NEVER,    S_FETCH};
            5'd8:  w = '{OP_NONE,      E_NONE,     C_MT_DONE,  S_DONE};
            5'd9:  w = '{OP_NONE,      E_NONE,     C_MT_REQ,   S_PREQ};
            5'd10: w = '{OP_NONE,      E_NONE,     C_MT_REP,   S_PREP};
            5'd11: w = '{OP_NONE,      E_NONE,     C_ALWAYS,   S_EMPTY};
            5'd12: w = '{OP_DONE_INC,  E_NONE,     C_ALWAYS,   S_EMPTY};
            5'd13: w = '{OP_NONE,      E_NONE,     C_DEFER,    S_DEFER};
            5'd14: w = '{OP_TICK,      E_NONE,     C_NEVER,    S_FETCH};
            5'd15: w = '{OP_NONE,      E_RPL_SND,  C_ALWAYS,   S_FETCH};
            5'd16: w = '{OP_DEFER,     E_NONE,     C_ALWAYS,   S_EMPTY};
            5'd17: w = '{OP_RPL_DEC,   E_NONE,     C_NEVER,    S_FETCH};
            5'd18: w = '{OP_NONE,      E_GRANT,    C_ALWAYS,   S_FETCH};
            5'd19: w = '{OP_REL_START, E_NONE,     C_NEVER,    S_FETCH};
            5'd20: w = '{OP_NONE,      E_NONE,     C_PEER_END, S_FIN};
            5'd21: w = '{OP_NONE,      E_NONE,     C_NOT_DEF,  S_NEXT};
            5'd22: w = '{OP_TICK,      E_NONE,     C_NEVER,    S_FETCH};
            5'd23: w = '{OP_NONE,      E_RPL_PEER, C_NEVER,    S_FETCH};
            5'd24: w = '{OP_IDX_INC,   E_NONE,     C_ALWAYS,   S_LOOP};
            5'd25: w = '{OP_REL_END,   E_NONE,     C_SENT,     S_FETCH};
            5'd26: w = '{OP_NONE,      E_NONE,     C_ALWAYS,   S_EMPTY};
            default: w = '{OP_NONE,    E_NONE,     C_ALWAYS,   S_FETCH};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/ricart_agrawala_mutex_node_unit.sv]
// Each item runs as a microcode routine from fetch back to fetch: request, unknown
// opcode, received message or release. A release visits the peer slots for ids 1 up to
// min(num_procs, MAX_PROCS, 16) - 1, replies to each deferred peer, and emits an empty
// result when nothing is deferred. Results are registered: each is valid in the cycle
// after its emit step, which holds while the output stalls. The node takes one item at a time.
// Reset: synchronous; all node state clears, own_id to 1, num_procs to 3. No clearing pass.
`default_nettype none
module ricart_agrawala_mutex_node_unit #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // sender_id, msg_stamp, zero pad
    input  wire logic [3:0]  s_axis_tuser,  // opcode, msg_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // action, dest_id, out_stamp, granted,
                                            // done_seen, zero pad
    output logic             m_axis_tlast
);

    localparam int MASK_W = (MAX_PROCS < 16) ? MAX_PROCS : 16;

    localparam logic REG_OWN_ID    = 1'b0;
    localparam logic REG_NUM_PROCS = 1'b1;

    logic [3:0]        r_own_id;
    logic [4:0]        r_num_procs;
    logic              cfg_wr;
    ramn_pkg::t_ctrl   ctrl;
    ramn_pkg::t_status status;
    logic [1:0]        action;
    logic [3:0]        dest_id;
    logic [14:0]       out_stamp;
    logic              granted;
    logic [3:0]        done_seen;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id    <= 4'd1;
            r_num_procs <= 5'd3;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_OWN_ID:    r_own_id    <= pwdata[3:0];
                REG_NUM_PROCS: r_num_procs <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OWN_ID:    prdata = {28'd0, r_own_id};
            REG_NUM_PROCS: prdata = {27'd0, r_num_procs};
            default:       prdata = 32'd0;
        endcase
    end

    ramn_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    ramn_dpath #(
        .MASK_W (MASK_W)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (s_axis_tvalid),
        .i_opcode    (s_axis_tuser[1:0]),
        .i_msg_type  (s_axis_tuser[3:2]),
        .i_sender_id (s_axis_tdata[3:0]),
        .i_msg_stamp (s_axis_tdata[18:4]),
        .i_own_id    (r_own_id),
        .i_num_procs (r_num_procs),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_action    (action),
        .o_dest_id   (dest_id),
        .o_out_stamp (out_stamp),
        .o_granted   (granted),
        .o_done_seen (done_seen),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, done_seen, granted, out_stamp, dest_id, action};

endmodule
`default_nettype wire

[rtl/ramn_useq.sv]
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none
module ramn_useq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ramn_pkg::t_status i_status,
    output ramn_pkg::t_ctrl       o_ctrl
);

    logic [ramn_pkg::STEP_W-1:0] r_step;
    logic [ramn_pkg::STEP_W-1:0] n_step;
    logic                        take;
    ramn_pkg::t_ctrl             ctrl;

    assign ctrl   = ramn_pkg::rom_word(r_step);
    assign o_ctrl = ctrl;

    always_comb begin
        unique case (ctrl.cond)
            ramn_pkg::C_NEVER:    take = 1'b0;
            ramn_pkg::C_ALWAYS:   take = 1'b1;
            ramn_pkg::C_NO_ITEM:  take = !i_status.item_valid;
            ramn_pkg::C_OP_REQ:   take = i_status.op_req;
            ramn_pkg::C_OP_MSG:   take = i_status.op_msg;
            ramn_pkg::C_OP_REL:   take = i_status.op_rel;
            ramn_pkg::C_MT_DONE:  take = i_status.mt_done;
            ramn_pkg::C_MT_REQ:   take = i_status.mt_req;
            ramn_pkg::C_MT_REP:   take = i_status.mt_rep;
            ramn_pkg::C_DEFER:    take = i_status.defer;
            ramn_pkg::C_PEER_END: take = i_status.peer_end;
            ramn_pkg::C_NOT_DEF:  take = i_status.not_def;
            ramn_pkg::C_SENT:     take = i_status.sent;
            default:              take = 1'b1;
        endcase
    end

    always_comb begin
        if (ctrl.emit != ramn_pkg::E_NONE && i_status.out_busy) begin
            n_step = r_step;
        end else if (take) begin
            n_step = ctrl.target;
        end else begin
            n_step = r_step + ramn_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ramn_pkg::S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

[rtl/ramn_dpath.sv]
// Datapath: Lamport clock, request state, deferred mask and result register.
`default_nettype none
module ramn_dpath #(
    parameter int MASK_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ramn_pkg::t_ctrl   i_ctrl,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [1:0]        i_msg_type,
    input  wire logic [3:0]        i_sender_id,
    input  wire logic [14:0]       i_msg_stamp,
    input  wire logic [3:0]        i_own_id,
    input  wire logic [4:0]        i_num_procs,
    input  wire logic              i_out_ready,
    output logic                   o_in_ready,
    output ramn_pkg::t_status      o_status,
    output logic                   o_out_valid,
    output logic [1:0]             o_action,
    output logic [3:0]             o_dest_id,
    output logic [14:0]            o_out_stamp,
    output logic                   o_granted,
    output logic [3:0]             o_done_seen,
    output logic                   o_last
);

    localparam int IDX_W = (MASK_W > 1) ? $clog2(MASK_W) : 1;
    localparam int CNT_W = $clog2(MASK_W + 1);

    logic [14:0]       r_clk, n_clk;
    logic [14:0]       r_req_stamp, n_req_stamp;
    logic              r_requesting, n_requesting;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [4:0]        r_replies, n_replies;
    logic [3:0]        r_fin, n_fin;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_sent, n_sent;
    logic              r_grant, n_grant;
    logic [1:0]        r_opcode, r_mtype;
    logic [3:0]        r_sender;
    logic [14:0]       r_stamp;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_action, n_action;
    logic [3:0]        r_dest, n_dest;
    logic [14:0]       r_ostamp, n_ostamp;
    logic              r_ogrant, n_ogrant;
    logic [3:0]        r_odone, n_odone;
    logic              r_olast, n_olast;

    logic              out_busy;
    logic              emit_fire;
    logic              later;
    logic              more;
    logic [MASK_W-1:0] ahead;
    logic [14:0]       hi_stamp;

    function automatic logic [14:0] tick(input logic [14:0] t);
        return (t < ramn_pkg::CLK_MAX) ? t + 15'd1 : t;
    endfunction

    assign out_busy   = r_out_valid && !i_out_ready;
    assign emit_fire  = (i_ctrl.emit != ramn_pkg::E_NONE) && !out_busy;
    assign o_in_ready = (i_ctrl.op == ramn_pkg::OP_LOAD) && i_rst_n;
    assign hi_stamp   = (r_stamp > r_clk) ? r_stamp : r_clk;
    assign later      = (r_stamp > r_req_stamp) ||
                        ((r_stamp == r_req_stamp) && (r_sender >= i_own_id));

    always_comb begin
        for (int j = 0; j < MASK_W; j++) begin
            ahead[j] = r_mask[j] && (CNT_W'(j) > r_idx) && (5'(j) < i_num_procs);
        end
    end
    assign more = |ahead;

    always_comb begin
        o_status.item_valid = i_in_valid;
        o_status.out_busy   = out_busy;
        o_status.op_req     = (r_opcode == ramn_pkg::OPC_REQ);
        o_status.op_msg     = (r_opcode == ramn_pkg::OPC_MSG);
        o_status.op_rel     = (r_opcode == ramn_pkg::OPC_REL);
        o_status.mt_done    = (r_mtype == ramn_pkg::MT_DONE);
        o_status.mt_req     = (r_mtype == ramn_pkg::MT_REQ);
        o_status.mt_rep     = (r_mtype == ramn_pkg::MT_REP);
        o_status.defer      = r_requesting && later;
        o_status.peer_end   = (r_idx >= CNT_W'(MASK_W)) || (5'(r_idx) >= i_num_procs);
        o_status.not_def    = !r_mask[r_idx[IDX_W-1:0]];
        o_status.sent       = r_sent;
    end

    always_comb begin
        n_clk        = r_clk;
        n_req_stamp  = r_req_stamp;
        n_requesting = r_requesting;
        n_mask       = r_mask;
        n_replies    = r_replies;
        n_fin        = r_fin;
        n_idx        = r_idx;
        n_sent       = r_sent;
        n_grant      = r_grant;
        unique case (i_ctrl.op)
            ramn_pkg::OP_REQ: begin
                n_clk        = tick(r_clk);
                n_req_stamp  = tick(r_clk);
                n_requesting = 1'b1;
                n_replies    = (i_num_procs > 5'd2) ? i_num_procs - 5'd2 : 5'd0;
            end
            ramn_pkg::OP_MAXTICK: n_clk = tick(hi_stamp);
            ramn_pkg::OP_DONE_INC: begin
                if (r_fin != 4'hF) begin
                    n_fin = r_fin + 4'd1;
                end
            end
            ramn_pkg::OP_TICK: n_clk = tick(r_clk);
            ramn_pkg::OP_DEFER: begin
                if ({1'b0, r_sender} < 5'(MASK_W)) begin
                    n_mask[r_sender[IDX_W-1:0]] = 1'b1;
                end
            end
            ramn_pkg::OP_RPL_DEC: begin
                if (r_requesting && r_replies != 5'd0) begin
                    n_replies = r_replies - 5'd1;
                    n_grant   = (r_replies == 5'd1);
                end else begin
                    n_grant = 1'b0;
                end
            end
            ramn_pkg::OP_REL_START: begin
                n_clk  = tick(r_clk);
                n_idx  = CNT_W'(1);
                n_sent = 1'b0;
            end
            ramn_pkg::OP_IDX_INC: n_idx = r_idx + CNT_W'(1);
            ramn_pkg::OP_REL_END: begin
                n_mask       = '0;
                n_requesting = 1'b0;
                n_replies    = 5'd0;
            end
            default: ;
        endcase
        if (emit_fire && i_ctrl.emit == ramn_pkg::E_RPL_PEER) begin
            n_sent = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_action    = r_action;
        n_dest      = r_dest;
        n_ostamp    = r_ostamp;
        n_ogrant    = r_ogrant;
        n_odone     = r_odone;
        n_olast     = r_olast;
        if (emit_fire) begin
            n_out_valid = 1'b1;
            n_action    = ramn_pkg::ACT_NONE;
            n_dest      = 4'd0;
            n_ostamp    = 15'd0;
            n_ogrant    = 1'b0;
            n_odone     = r_fin;
            n_olast     = 1'b1;
            unique case (i_ctrl.emit)
                ramn_pkg::E_MCAST: begin
                    n_action = ramn_pkg::ACT_MCAST;
                    n_ostamp = r_clk;
                    n_ogrant = (r_replies == 5'd0);
                end
                ramn_pkg::E_RPL_SND: begin
                    n_action = ramn_pkg::ACT_REPLY;
                    n_dest   = r_sender;
                    n_ostamp = r_clk;
                end
                ramn_pkg::E_RPL_PEER: begin
                    n_action = ramn_pkg::ACT_REPLY;
                    n_dest   = 4'(r_idx);
                    n_ostamp = r_clk;
                    n_olast  = !more;
                end
                ramn_pkg::E_GRANT: n_ogrant = r_grant;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk        <= 15'd0;
            r_req_stamp  <= 15'd0;
            r_requesting <= 1'b0;
            r_mask       <= '0;
            r_replies    <= 5'd0;
            r_fin        <= 4'd0;
            r_idx        <= '0;
            r_sent       <= 1'b0;
            r_grant      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_clk        <= n_clk;
            r_req_stamp  <= n_req_stamp;
            r_requesting <= n_requesting;
            r_mask       <= n_mask;
            r_replies    <= n_replies;
            r_fin        <= n_fin;
            r_idx        <= n_idx;
            r_sent       <= n_sent;
            r_grant      <= n_grant;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_opcode <= i_opcode;
            r_mtype  <= i_msg_type;
            r_sender <= i_sender_id;
            r_stamp  <= i_msg_stamp;
        end
        r_action <= n_action;
        r_dest   <= n_dest;
        r_ostamp <= n_ostamp;
        r_ogrant <= n_ogrant;
        r_odone  <= n_odone;
        r_olast  <= n_olast;
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;
    assign o_dest_id   = r_dest;
    assign o_out_stamp = r_ostamp;
    assign o_granted   = r_ogrant;
    assign o_done_seen = r_odone;
    assign o_last      = r_olast;

endmodule
`default_nettype wire

[test/tb_ricart_agrawala_mutex_node_unit.sv]
// Self-checking testbench for the Ricart-Agrawala mutex node.
module tb_ricart_agrawala_mutex_node_unit;

    localparam int HALF_PERIOD   = 4;
    localparam int RST_CYCLES    = 11;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 24;
    localparam int NODE_PROCS    = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int REG_OWN_ID    = 0;
    localparam int REG_NUM_PROCS = 1;
    localparam logic [1:0] OPC_BAD = 2'd3;
    localparam logic [1:0] MT_BAD  = 2'd3;

    typedef struct {
        logic [1:0]  opcode;
        logic [1:0]  mtype;
        logic [3:0]  sender;
        logic [14:0] stamp;
        bit          rel;   // stamp taken relative to the current request stamp
        int          ofs;
    } t_node_msg;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  dest;
        logic [14:0] stamp;
        logic        granted;
        logic [3:0]  done_seen;
        logic        last;
    } t_node_act;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // sender_id, msg_stamp, zero pad
    logic [3:0]  s_axis_tuser = '0;  // opcode, msg_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // action, dest_id, out_stamp, granted, done_seen, zero pad
    logic        m_axis_tlast;

    ricart_agrawala_mutex_node_unit #(
        .MAX_PROCS(NODE_PROCS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // node state mirror
    logic [3:0]  own_m = 4'd1;
    logic [4:0]  nprocs_m = 5'd3;
    logic [14:0] lclock_m = '0;
    logic [14:0] req_stamp_m = '0;
    logic        requesting_m = 1'b0;
    logic [15:0] deferred_m = '0;
    logic [4:0]  replies_m = '0;
    logic [3:0]  finished_m = '0;
    t_node_act   held;
    bit          held_v = 1'b0;

    t_node_act actions_due[$];
    t_node_msg pending[$];
    t_node_msg on_wire;

    int queued_n = 0;
    int taken_n = 0;
    int checked_n = 0;
    int err_n = 0;
    int grants_n = 0;
    int settings_n = 0;
    int quiet_n = 0;
    int send_idle = 30;
    int recv_idle = 69;
    bit hold_go = 1'b0;
    bit hold_started = 1'b0;
    int hold_left = 0;

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic logic [14:0] lamport_tick(input logic [14:0] t);
        return (t == ramn_pkg::CLK_MAX) ? t : t + 15'd1;
    endfunction

    // results of one item are held back by one so the final one can carry last
    function automatic void emit_action(input logic [1:0] act, input logic [3:0] dst,
                                        input logic [14:0] stmp, input logic gr);
        if (held_v)
            actions_due.push_back(held);
        held = '{act, dst, stmp, gr, finished_m, 1'b0};
        held_v = 1'b1;
    endfunction

    function automatic void advance_node(input t_node_msg it);
        logic [14:0] hi;
        logic        later;
        int          i;
        held_v = 1'b0;
        case (it.opcode)
            ramn_pkg::OPC_REQ: begin
                lclock_m = lamport_tick(lclock_m);
                req_stamp_m = lclock_m;
                requesting_m = 1'b1;
                replies_m = (nprocs_m > 5'd2) ? nprocs_m - 5'd2 : 5'd0;
                emit_action(ramn_pkg::ACT_MCAST, 4'd0, lclock_m, replies_m == 5'd0);
            end
            ramn_pkg::OPC_MSG: begin
                hi = (it.stamp > lclock_m) ? it.stamp : lclock_m;
                lclock_m = lamport_tick(hi);
                case (it.mtype)
                    ramn_pkg::MT_DONE: begin
                        if (finished_m != 4'd15)
                            finished_m = finished_m + 4'd1;
                        emit_action(ramn_pkg::ACT_NONE, 4'd0, 15'd0, 1'b0);
                    end
                    ramn_pkg::MT_REQ: begin
                        later = (it.stamp > req_stamp_m) ||
                                (it.stamp == req_stamp_m && it.sender >= own_m);
                        if (requesting_m && later) begin
                            deferred_m[it.sender] = 1'b1;
                            emit_action(ramn_pkg::ACT_NONE, 4'd0, 15'd0, 1'b0);
                        end else begin
                            lclock_m = lamport_tick(lclock_m);
                            emit_action(ramn_pkg::ACT_REPLY, it.sender, lclock_m, 1'b0);
                        end
                    end
                    ramn_pkg::MT_REP: begin
                        later = 1'b0;
                        if (requesting_m && replies_m != 5'd0) begin
                            replies_m = replies_m - 5'd1;
                            later = (replies_m == 5'd0);
                        end
                        emit_action(ramn_pkg::ACT_NONE, 4'd0, 15'd0, later);
                    end
                    default: emit_action(ramn_pkg::ACT_NONE, 4'd0, 15'd0, 1'b0);
                endcase
            end
            ramn_pkg::OPC_REL: begin
                lclock_m = lamport_tick(lclock_m);
                for (i = 1; i < 16 && i < NODE_PROCS && i < nprocs_m; i++) begin
                    if (deferred_m[i]) begin
                        lclock_m = lamport_tick(lclock_m);
                        emit_action(ramn_pkg::ACT_REPLY, 4'(i), lclock_m, 1'b0);
                    end
                end
                deferred_m = '0;
                requesting_m = 1'b0;
                replies_m = '0;
                if (!held_v)
                    emit_action(ramn_pkg::ACT_NONE, 4'd0, 15'd0, 1'b0);
            end
            default: emit_action(ramn_pkg::ACT_NONE, 4'd0, 15'd0, 1'b0);
        endcase
        held.last = 1'b1;
        actions_due.push_back(held);
        held_v = 1'b0;
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        t_node_msg nx;
        logic      v;
        int        sv;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_node(on_wire);
                taken_n++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                v = 1'b0;
                if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                    nx = pending.pop_front();
                    if (nx.rel) begin
                        sv = int'(req_stamp_m) + nx.ofs;
                        if (sv < 0)
                            sv = 0;
                        if (sv > 32767)
                            sv = 32767;
                        nx.stamp = 15'(sv);
                    end
                    on_wire = nx;
                    s_axis_tdata <= {5'd0, nx.stamp, nx.sender};
                    s_axis_tuser <= {nx.mtype, nx.opcode};
                    v = 1'b1;
                end
                s_axis_tvalid <= v;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin : mon
        t_node_act got;
        t_node_act want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[20:6],
                        m_axis_tdata[21], m_axis_tdata[25:22], m_axis_tlast};
                checked_n++;
                if (got.granted === 1'b1)
                    grants_n++;
                if (actions_due.size() == 0) begin
                    err_n++;
                    if (err_n <= MAX_REPORTS)
                        $display("Unexpected result %0d: act=%0d dst=%0d stamp=%0d %s",
                                 checked_n, got.action, got.dest, got.stamp,
                                 $sformatf("gr=%0d done=%0d last=%0d",
                                           got.granted, got.done_seen, got.last));
                end else begin
                    want = actions_due.pop_front();
                    if (got !== want) begin
                        err_n++;
                        if (err_n <= MAX_REPORTS) begin
                            $display("Mismatch at result %0d: want act=%0d dst=%0d stamp=%0d %s",
                                     checked_n, want.action, want.dest, want.stamp,
                                     $sformatf("gr=%0d done=%0d last=%0d",
                                               want.granted, want.done_seen, want.last));
                            $display("    got act=%0d dst=%0d stamp=%0d %s",
                                     got.action, got.dest, got.stamp,
                                     $sformatf("gr=%0d done=%0d last=%0d",
                                               got.granted, got.done_seen, got.last));
                        end
                    end
                end
            end
            if (hold_go && !hold_started && actions_due.size() > 0) begin
                hold_started = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable && pwrite && pready))
                quiet_n <= 0;
            else
                quiet_n <= quiet_n + 1;
            if (quiet_n >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic add_item(input logic [1:0] opc, input logic [1:0] mt, input logic [3:0] snd,
                            input logic [14:0] stmp, input bit rel, input int ofs);
        pending.push_back('{opc, mt, snd, stmp, rel, ofs});
        queued_n++;
    endtask

    task automatic add_noise();
        add_item(2'($urandom_range(3)), 2'($urandom_range(3)), 4'($urandom),
                 15'($urandom_range(0, 300)), bit'($urandom_range(1)),
                 int'($urandom_range(0, 8)) - 4);
    endtask

    task automatic reg_write(input int idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_node(input logic [3:0] own, input logic [4:0] np);
        reg_write(REG_OWN_ID, {28'd0, own});
        reg_write(REG_NUM_PROCS, {27'd0, np});
        own_m = own;
        nprocs_m = np;
        settings_n++;
    endtask

    task automatic drain();
        while (taken_n != queued_n || actions_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // rounds of request, shuffled peer traffic and release, with some noise
    task automatic fill_random(input int np);
        int base;
        int top;
        int reps;
        int reqs;
        int dones;
        int pick;
        int ofs;
        logic [3:0] snd;
        base = queued_n;
        top = ((np > 16) ? 16 : np) - 1;
        if (top < 1)
            top = 1;
        while (queued_n - base < PHASE_ITEMS) begin
            if ($urandom_range(3) == 0)
                add_noise();
            add_item(ramn_pkg::OPC_REQ, 2'($urandom), 4'($urandom), 15'($urandom), 1'b0, 0);
            reps = (np > 2) ? np - 2 : 0;
            if (reps > 0 && $urandom_range(5) == 0)
                reps--;
            reqs = $urandom_range(0, 4);
            dones = $urandom_range(0, 2);
            while (reps + reqs + dones > 0) begin
                pick = $urandom_range(reps + reqs + dones - 1);
                if (pick < reps) begin
                    add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REP, 4'($urandom_range(1, top)),
                             15'd0, 1'b1, int'($urandom_range(0, 6)) - 3);
                    reps--;
                end else if (pick < reps + reqs) begin
                    snd = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(1, top));
                    ofs = ($urandom_range(9) == 0) ? int'($urandom_range(20, 600))
                                                   : int'($urandom_range(0, 6)) - 3;
                    add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, snd, 15'd0, 1'b1, ofs);
                    reqs--;
                end else begin
                    add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_DONE, 4'($urandom), 15'd0, 1'b1,
                             int'($urandom_range(0, 4)) - 2);
                    dones--;
                end
                if ($urandom_range(15) == 0)
                    add_noise();
            end
            if ($urandom_range(7) != 0)
                add_item(ramn_pkg::OPC_REL, 2'($urandom), 4'($urandom), 15'($urandom), 1'b0, 0);
        end
    endtask

    initial begin : stim
        int p;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_node(4'd5, 5'd6);
        add_item(ramn_pkg::OPC_REL, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0); // release idle
        add_item(OPC_BAD, ramn_pkg::MT_DONE, 4'd7, 15'd9, 1'b0, 0);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0);
        add_item(ramn_pkg::OPC_MSG, MT_BAD, 4'd9, 15'd3, 1'b0, 0);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REP, 4'd1, 15'd0, 1'b0, 0);   // stray reply
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'd15, 15'd10, 1'b0, 0); // answered
        add_item(ramn_pkg::OPC_REQ, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'd2, 15'd0, 1'b1, 5);   // later: deferred
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'd5, 15'd0, 1'b1, 0);   // tie, same id
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'd4, 15'd0, 1'b1, 0);   // tie, lower id
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'd3, 15'd0, 1'b1, -1);  // earlier
        add_item(ramn_pkg::OPC_REQ, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0);  // restart
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'd15, 15'd0, 1'b1, 2);  // beyond procs
        for (p = 1; p <= 4; p++)
            add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REP, 4'(p), 15'd0, 1'b1, -2);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REP, 4'd1, 15'd0, 1'b1, 0);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_DONE, 4'd2, 15'd0, 1'b1, 1);
        add_item(ramn_pkg::OPC_REL, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0);
        add_item(ramn_pkg::OPC_REL, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0);
        drain();

        set_node(4'd15, 5'd16);
        fill_random(16);
        drain();

        send_idle = 69;
        recv_idle = 30;
        set_node(4'd1, 5'd3);
        fill_random(3);
        drain();

        send_idle = 0;
        recv_idle = 0;
        set_node(4'($urandom_range(1, 15)), 5'd2);              // below three: granted at once
        fill_random(2);
        drain();

        hold_go = 1'b1;
        set_node(4'($urandom_range(1, 15)), 5'd31);
        fill_random(31);
        drain();

        // large stamps, a full release and clock saturation
        set_node(4'd15, 5'd16);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_DONE, 4'hA, 15'h2AAA, 1'b0, 0);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_DONE, 4'h5, 15'h5555, 1'b0, 0);
        add_item(ramn_pkg::OPC_REQ, MT_BAD, 4'hF, 15'h7FFF, 1'b0, 0);
        for (p = 1; p < 16; p++)
            add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'(p), 15'd0, 1'b1, 1);
        add_item(ramn_pkg::OPC_REL, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0);
        add_item(ramn_pkg::OPC_MSG, MT_BAD, 4'd0, 15'h7FFF, 1'b0, 0);
        add_item(ramn_pkg::OPC_REQ, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'd15, 15'd0, 1'b1, 0);
        add_item(ramn_pkg::OPC_MSG, ramn_pkg::MT_REQ, 4'd14, 15'd0, 1'b1, 0);
        add_item(ramn_pkg::OPC_REL, ramn_pkg::MT_DONE, 4'd0, 15'd0, 1'b0, 0);
        drain();

        $display("Run: %0d items in, %0d results checked, %0d grants, %0d node settings",
                 taken_n, checked_n, grants_n, settings_n);
        $display("Exercised deferral ties, restarts, stray replies, a long output stall,");
        $display("a full release and clock saturation");
        if (err_n == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
